>>> rtl/absnd_pkg.sv
// Shared types, codes and helpers of the alternating-bit sender.
// Depends on nothing; imported by the sender top level and its checker.
package absnd_pkg;

  localparam int PAYLOAD_BYTES  = 20;
  localparam int PAYLOAD_W      = PAYLOAD_BYTES * 8;
  // 20 signed bytes sum to -2560 .. 2540
  localparam int SUM_W          = 13;
  localparam int FIFO_DEPTH_DEF = 16;

  typedef logic [PAYLOAD_W-1:0]    payload_t;
  typedef logic signed [SUM_W-1:0] bsum_t;

  localparam logic [1:0] MODE_MSG   = 2'd0;
  localparam logic [1:0] MODE_NET   = 2'd1;
  localparam logic [1:0] MODE_TIMER = 2'd2;

  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // Keep the bytes before the first zero byte, clear the rest.
  function automatic payload_t clip_at_zero(payload_t m);
    logic     ended;
    payload_t r;
    ended = 1'b0;
    r     = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (m[i*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) r[i*8 +: 8] = m[i*8 +: 8];
    end
    return r;
  endfunction

  // Sum of all payload bytes, each taken as signed; adder tree over groups of four.
  function automatic bsum_t byte_sum(payload_t m);
    bsum_t b [PAYLOAD_BYTES];
    bsum_t g [PAYLOAD_BYTES/4];
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      b[i] = {{(SUM_W-8){m[i*8+7]}}, m[i*8 +: 8]};
    end
    for (int k = 0; k < PAYLOAD_BYTES/4; k++) begin
      g[k] = (b[4*k] + b[4*k+1]) + (b[4*k+2] + b[4*k+3]);
    end
    return ((g[0] + g[1]) + (g[2] + g[3])) + g[4];
  endfunction

  function automatic logic [31:0] sext_sum(bsum_t s);
    return {{(32-SUM_W){s[SUM_W-1]}}, s};
  endfunction

endpackage

>>> rtl/alternating_bit_sender_top.sv
// Alternating-bit sender: request register, event logic, wait queue and result register.
// Depends on absnd_pkg for codes, payload clipping and byte checksum.
//
// Sender half of an alternating-bit link. Each request is a message, an arriving
// packet or a timer expiry, and produces exactly one result. A request taken into the
// request register passes to the result register, which a stalled result side holds
// back. A new request is taken in every cycle while out_ready does not stall the
// result; throughput is then one event per cycle, set by the single pass through the
// clip, byte-sum and checksum compare logic and by the registered read of the wait
// queue, whose head entry is prefetched so that an acknowledgement can send it at
// once. Messages that arrive while a packet is unacknowledged wait in a FIFO_DEPTH-entry
// queue; when it is full the message is dropped and out_overflow is reported.
module alternating_bit_sender_top
  import absnd_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [63:0]        in_payload_word0,
  input  logic [63:0]        in_payload_word1,
  input  logic [31:0]        in_payload_word2,
  input  logic signed [31:0] in_seq,
  input  logic signed [31:0] in_ack,
  input  logic signed [31:0] in_checksum,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_send_valid,
  output logic               out_seq,
  output logic [63:0]        out_word0,
  output logic [63:0]        out_word1,
  output logic [31:0]        out_word2,
  output logic signed [31:0] out_checksum,
  output logic [1:0]         out_timer_action,
  output logic               out_ack_taken,
  output logic               out_queued,
  output logic               out_overflow
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int EW = SUM_W + PAYLOAD_W;

  // request register
  logic              s1_valid_r;
  logic [1:0]        s1_mode_r;
  payload_t          s1_msg_r;
  logic [31:0]       s1_seq_r, s1_ack_r, s1_chk_r;

  // protocol state
  logic              cur_seq_r, cur_seq_nxt;
  logic              acked_r, acked_nxt;
  payload_t          saved_pl_r, saved_pl_nxt;
  logic [31:0]       saved_chk_r, saved_chk_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // wait queue: clipped payload plus its byte sum
  logic [EW-1:0]     mem [FIFO_DEPTH];
  logic [EW-1:0]     rd_data_r;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [EW-1:0]     wr_data;

  // result register
  logic              out_valid_r;
  logic              res_send, res_seq, res_ack, res_queued, res_ovf;
  logic [1:0]        res_tmr;
  payload_t          res_pl;
  logic [31:0]       res_chk;
  logic              o_send_r, o_seq_r, o_ack_r, o_queued_r, o_ovf_r;
  logic [1:0]        o_tmr_r;
  payload_t          o_pl_r;
  logic [31:0]       o_chk_r;

  logic              adv;
  payload_t          msg_clip;
  bsum_t             clip_sum, raw_sum;
  logic [31:0]       net_sum;
  logic [CW:0]       tail_sum;
  logic              do_send;
  payload_t          send_pl;
  bsum_t             send_sum;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r <= in_mode;
      s1_msg_r  <= {in_payload_word2, in_payload_word1, in_payload_word0};
      s1_seq_r  <= in_seq;
      s1_ack_r  <= in_ack;
      s1_chk_r  <= in_checksum;
    end
  end

  assign msg_clip = clip_at_zero(s1_msg_r);
  assign clip_sum = byte_sum(msg_clip);
  assign raw_sum  = byte_sum(s1_msg_r);
  assign net_sum  = s1_seq_r + s1_ack_r + sext_sum(raw_sum);

  // tail = (head + count) mod depth; the sum stays below twice the depth
  assign tail_sum = {{(CW+1-AW){1'b0}}, head_r} + {1'b0, count_r};
  assign wr_addr  = (tail_sum >= (CW+1)'(FIFO_DEPTH)) ?
                    AW'(tail_sum - (CW+1)'(FIFO_DEPTH)) : AW'(tail_sum);
  assign wr_data  = {clip_sum, msg_clip};

  always_comb begin
    cur_seq_nxt   = cur_seq_r;
    acked_nxt     = acked_r;
    saved_pl_nxt  = saved_pl_r;
    saved_chk_nxt = saved_chk_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    do_send       = 1'b0;
    send_pl       = msg_clip;
    send_sum      = clip_sum;
    res_send      = 1'b0;
    res_seq       = 1'b0;
    res_pl        = '0;
    res_chk       = '0;
    res_tmr       = TMR_NONE;
    res_ack       = 1'b0;
    res_queued    = 1'b0;
    res_ovf       = 1'b0;
    case (s1_mode_r)
      MODE_MSG: begin
        if (acked_r) begin
          do_send = 1'b1;
          res_tmr = TMR_START;
        end else if (count_r == CW'(FIFO_DEPTH)) begin
          res_ovf = 1'b1;
        end else begin
          wr_en      = 1'b1;
          count_nxt  = count_r + 1'b1;
          res_queued = 1'b1;
        end
      end
      MODE_NET: begin
        if (net_sum == s1_chk_r && s1_ack_r == {31'b0, cur_seq_r}) begin
          acked_nxt = 1'b1;
          res_ack   = 1'b1;
          res_tmr   = TMR_STOP;
          if (count_r != '0) begin
            do_send   = 1'b1;
            send_pl   = rd_data_r[PAYLOAD_W-1:0];
            send_sum  = rd_data_r[EW-1:PAYLOAD_W];
            res_tmr   = TMR_RESTART;
            head_nxt  = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      MODE_TIMER: begin
        res_send = 1'b1;
        res_seq  = cur_seq_r;
        res_pl   = saved_pl_r;
        res_chk  = saved_chk_r;
        res_tmr  = TMR_START;
      end
      default: begin
      end
    endcase
    if (do_send) begin
      cur_seq_nxt   = ~cur_seq_r;
      acked_nxt     = 1'b0;
      saved_pl_nxt  = send_pl;
      saved_chk_nxt = {31'b0, ~cur_seq_r} + sext_sum(send_sum);
      res_send      = 1'b1;
      res_seq       = ~cur_seq_r;
      res_pl        = send_pl;
      res_chk       = saved_chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_seq_r   <= 1'b1;
      acked_r     <= 1'b1;
      saved_pl_r  <= '0;
      saved_chk_r <= '0;
      head_r      <= '0;
      count_r     <= '0;
    end else if (adv) begin
      cur_seq_r   <= cur_seq_nxt;
      acked_r     <= acked_nxt;
      saved_pl_r  <= saved_pl_nxt;
      saved_chk_r <= saved_chk_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  // prefetch the head entry for the state after this cycle; forward a same-slot write
  assign rd_addr = adv ? head_nxt : head_r;

  always_ff @(posedge clk) begin
    if (adv && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv && wr_en && wr_addr == rd_addr) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_send_r   <= res_send;
      o_seq_r    <= res_seq;
      o_pl_r     <= res_pl;
      o_chk_r    <= res_chk;
      o_tmr_r    <= res_tmr;
      o_ack_r    <= res_ack;
      o_queued_r <= res_queued;
      o_ovf_r    <= res_ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_valid   = o_send_r;
  assign out_seq          = o_seq_r;
  assign out_word0        = o_pl_r[63:0];
  assign out_word1        = o_pl_r[127:64];
  assign out_word2        = o_pl_r[159:128];
  assign out_checksum     = o_chk_r;
  assign out_timer_action = o_tmr_r;
  assign out_ack_taken    = o_ack_r;
  assign out_queued       = o_queued_r;
  assign out_overflow     = o_ovf_r;

endmodule

>>> rtl/absnd_checker.sv
// Port-level checks of the alternating-bit sender and the bind that attaches them.
// Depends on absnd_pkg for timer action codes; bound to alternating_bit_sender_top.
module absnd_checker
  import absnd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_send_valid,
  input logic        out_seq,
  input logic [63:0] out_word0,
  input logic [63:0] out_word1,
  input logic [31:0] out_word2,
  input logic [31:0] out_checksum,
  input logic [1:0]  out_timer_action,
  input logic        out_ack_taken,
  input logic        out_queued,
  input logic        out_overflow
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_checksum) &&
      $stable(out_send_valid) && $stable(out_timer_action) && $stable(out_word0))
    else $error("stalled result changed");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> !out_seq && out_checksum == '0 &&
      out_word0 == '0 && out_word1 == '0 && out_word2 == '0)
    else $error("payload fields set without a send");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_send_valid, out_queued, out_overflow}) <= 1)
    else $error("send, queue and drop reported together");

  a_ack_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ack_taken |->
      (out_timer_action == TMR_STOP && !out_send_valid) ||
      (out_timer_action == TMR_RESTART && out_send_valid))
    else $error("acknowledgement with wrong timer action");

endmodule

bind alternating_bit_sender_top absnd_checker u_absnd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_send_valid   (out_send_valid),
  .out_seq          (out_seq),
  .out_word0        (out_word0),
  .out_word1        (out_word1),
  .out_word2        (out_word2),
  .out_checksum     (out_checksum),
  .out_timer_action (out_timer_action),
  .out_ack_taken    (out_ack_taken),
  .out_queued       (out_queued),
  .out_overflow     (out_overflow)
);
